/* rtl/itda_pkg.sv */
package itda_pkg;

    // width of the signed input word
    localparam int VALUE_BITS = 32;

    // decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
    localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

    localparam int DIGIT_BITS = 4;
    localparam int CHAR_BITS  = 6;

    localparam int BIT_CNT_W = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W = $clog2(DIGITS + 1);

    localparam logic [CHAR_BITS-1:0]  CH_ZERO   = 6'd48;
    localparam logic [CHAR_BITS-1:0]  CH_MINUS  = 6'd45;
    localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = 4'd9;

    // control broadcast to every digit cell
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 correct, then shift one bit in from below
        logic move;    // take the whole digit of the cell below
    } t_cell_ctrl;

endpackage

/* rtl/int_to_decimal_ascii.sv */
// channel   direction   handshake            payload
// input     in          i_valid / o_ready    i_value (32 bit signed)
// output    out         o_valid / i_ready    o_char_code (6 bit), o_last
//
// one input transfer is loaded, then converted by bit-serial double dabble
// through the row of ten digit cells; then leading zeros are skipped and
// the characters are sent. a new input is taken only once the last
// character has entered the character register. the dabble loop over the
// value bits takes the bulk of the conversion time.
// reset is synchronous, active low, and clears the control state only.
// an output stall holds the character register and freezes the digit row, but leading zeros are still skipped.
module int_to_decimal_ascii (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [itda_pkg::VALUE_BITS-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [itda_pkg::CHAR_BITS-1:0]      o_char_code,
    output logic                                o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state                                r_state;
    logic [itda_pkg::VALUE_BITS-1:0]       r_mag;       // magnitude, shifted out msb first
    logic                                  r_neg;       // minus sign still to send
    logic                                  r_started;   // first nonzero digit seen
    logic [itda_pkg::BIT_CNT_W-1:0]        r_bit_cnt;
    logic [itda_pkg::DIG_CNT_W-1:0]        r_dig_left;  // digits still in the row
    logic                                  r_out_valid;
    logic [itda_pkg::CHAR_BITS-1:0]        r_char;
    logic                                  r_last;

    logic [itda_pkg::VALUE_BITS-1:0]       w_mag_in;
    logic                                  w_out_free;
    logic                                  w_skip;
    logic [itda_pkg::DIGIT_BITS-1:0]       w_top;
    itda_pkg::t_cell_ctrl                  w_ctrl;

    // carry and digit links of the cell row, cell 0 holds the units digit
    logic                                  w_carry [itda_pkg::DIGITS];
    logic [itda_pkg::DIGIT_BITS-1:0]       w_digit [itda_pkg::DIGITS];

    // two's complement negate; the most negative value wraps to 2^(n-1),
    // which is exactly its magnitude read as unsigned
    assign w_mag_in = i_value[itda_pkg::VALUE_BITS-1]
                      ? itda_pkg::VALUE_BITS'(~i_value + 1'b1)
                      : itda_pkg::VALUE_BITS'(i_value);

    assign w_out_free = !r_out_valid || i_ready;
    assign w_top      = w_digit[itda_pkg::DIGITS-1];

    // drop leading zeros, but always keep the units digit
    assign w_skip = (w_top == '0) && !r_started
                    && (r_dig_left > itda_pkg::DIG_CNT_W'(1));

    always_comb begin
        w_ctrl.clear  = (r_state == S_IDLE) && i_valid;
        w_ctrl.dabble = (r_state == S_CONV);
        w_ctrl.move   = (r_state == S_EMIT) && !r_neg && (w_skip || w_out_free);
    end

    // row of digit cells
    for (genvar g = 0; g < itda_pkg::DIGITS; g++) begin : g_cell
        itda_bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_bit   ((g == 0) ? r_mag[itda_pkg::VALUE_BITS-1] : w_carry[(g == 0) ? 0 : g-1]),
            .i_digit ((g == 0) ? '0 : w_digit[(g == 0) ? 0 : g-1]),
            .o_bit   (w_carry[g]),
            .o_digit (w_digit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_neg       <= 1'b0;
            r_started   <= 1'b0;
            r_bit_cnt   <= '0;
            r_dig_left  <= '0;
        end else begin
            // character register empties on a transfer
            if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mag     <= w_mag_in;
                        r_neg     <= i_value[itda_pkg::VALUE_BITS-1];
                        r_bit_cnt <= itda_pkg::BIT_CNT_W'(itda_pkg::VALUE_BITS - 1);
                        r_state   <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_mag <= r_mag << 1;
                    if (r_bit_cnt == '0) begin
                        r_dig_left <= itda_pkg::DIG_CNT_W'(itda_pkg::DIGITS);
                        r_started  <= 1'b0;
                        r_state    <= S_EMIT;
                    end else begin
                        r_bit_cnt <= r_bit_cnt - 1'b1;
                    end
                end
                S_EMIT: begin
                    priority if (r_neg) begin
                        if (w_out_free) begin
                            r_char      <= itda_pkg::CH_MINUS;
                            r_last      <= 1'b0;
                            r_out_valid <= 1'b1;
                            r_neg       <= 1'b0;
                        end
                    end else if (w_skip) begin
                        r_dig_left <= r_dig_left - 1'b1;
                    end else if (w_out_free) begin
                        r_char      <= itda_pkg::CH_ZERO + {2'b00, w_top};
                        r_last      <= (r_dig_left == itda_pkg::DIG_CNT_W'(1));
                        r_out_valid <= 1'b1;
                        r_started   <= 1'b1;
                        r_dig_left  <= r_dig_left - 1'b1;
                        if (r_dig_left == itda_pkg::DIG_CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        // output stalled, wait with the row frozen
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    // the top cell never overflows while dabbling
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> !w_carry[itda_pkg::DIGITS-1])
        else $error("digit row overflow");

    // an input transfer always starts a conversion
    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_CONV))
        else $error("accepted item did not start conversion");

    // while sending, at least one digit remains in the row
    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_dig_left != '0))
        else $error("emit with no digits left");

    // the digit under the output is a valid decimal digit
    a_bcd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (w_top <= itda_pkg::DIGIT_MAX))
        else $error("top digit out of decimal range");

endmodule

/* rtl/itda_bcd_cell.sv */
module itda_bcd_cell (
    input  logic                                i_clk,
    input  itda_pkg::t_cell_ctrl                i_ctrl,
    input  logic                                i_bit,
    input  logic [itda_pkg::DIGIT_BITS-1:0]     i_digit,
    output logic                                o_bit,
    output logic [itda_pkg::DIGIT_BITS-1:0]     o_digit
);

    logic [itda_pkg::DIGIT_BITS-1:0] r_digit;
    logic [itda_pkg::DIGIT_BITS-1:0] w_adj;

    // add 3 when the digit would reach ten or more after doubling
    assign w_adj   = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_bit   = w_adj[itda_pkg::DIGIT_BITS-1];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.clear) begin
            r_digit <= '0;
        end else if (i_ctrl.dabble) begin
            r_digit <= {w_adj[itda_pkg::DIGIT_BITS-2:0], i_bit};
        end else if (i_ctrl.move) begin
            r_digit <= i_digit;
        end else begin
            // hold
            r_digit <= r_digit;
        end
    end

endmodule
